/* rtl/twc_pkg.sv */
// Shared types and constants for the textured wall column renderer.
// No dependencies; every other file in rtl except twc_div imports this package.
package twc_pkg;

    // Request function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Pixel region codes
    localparam logic [1:0] RGN_CEILING = 2'd0;
    localparam logic [1:0] RGN_WALL    = 2'd1;
    localparam logic [1:0] RGN_FLOOR   = 2'd2;

    // Wall texture codes
    localparam logic [1:0] TEX_EAST  = 2'd0;
    localparam logic [1:0] TEX_NORTH = 2'd1;
    localparam logic [1:0] TEX_WEST  = 2'd2;
    localparam logic [1:0] TEX_SOUTH = 2'd3;

    // Configuration register indexes (byte address 4*index)
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd0;
    localparam logic [2:0] REG_TEXTURE_WIDTH = 3'd1;
    localparam logic [2:0] REG_TEX_H_LOG2    = 3'd2;
    localparam logic [2:0] REG_CEILING_COLOR = 3'd3;
    localparam logic [2:0] REG_FLOOR_COLOR   = 3'd4;

    // Configuration register set
    typedef struct packed {
        logic [11:0] screen_height;
        logic [10:0] texture_width;
        logic [3:0]  tex_h_log2;
        logic [23:0] ceiling_color;
        logic [23:0] floor_color;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load_col;
        logic hit_mul;
        logic frac_add;
        logic tex_mul;
        logic tex_mirror;
        logic pos_mul;
        logic pixel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_busy;
        logic col_active;
    } t_status;

endpackage

/* rtl/textured_wall_column_renderer_unit.sv */
// Textured wall column renderer: a column-start request is held in setup
// until the bit-serial step divider, which runs beside the hit point
// multiplies, is done; no request is taken meanwhile. Pixel requests then
// stream at one per cycle while the result side is not stalled, through a
// single output register, and a pixel request with no column loaded is
// taken without a result. Configuration sits behind an APB port, one 32-bit
// register every 4 bytes.
// Depends on twc_pkg, twc_ctrl, twc_datapath and twc_div.
module textured_wall_column_renderer_unit #(
    parameter int FRAC_BITS       = 16,
    parameter int MAX_TEX_SIZE    = 1024,
    parameter int MAX_SCREEN_ROWS = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    input  logic [11:0]         i_column,
    input  logic                i_side,
    input  logic signed [31:0]  i_ray_dir_x,
    input  logic signed [31:0]  i_ray_dir_y,
    input  logic [31:0]         i_pos_x,
    input  logic [31:0]         i_pos_y,
    input  logic [31:0]         i_wall_dist,
    input  logic [15:0]         i_line_height,
    input  logic [10:0]         i_draw_start,
    input  logic [11:0]         i_draw_end,
    // Result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [11:0]         o_out_column,
    output logic [10:0]         o_row,
    output logic [1:0]          o_region,
    output logic [1:0]          o_texture_select,
    output logic [9:0]          o_tex_x,
    output logic [9:0]          o_tex_y,
    output logic [23:0]         o_color,
    output logic                o_last
);
    import twc_pkg::*;

    t_cfg       r_cfg;
    t_cmd       w_cmd;
    t_status    w_status;
    logic [2:0] w_index;
    logic       w_wr;

    assign pready  = 1'b1;
    assign w_index = paddr[4:2];
    assign w_wr    = psel && penable && pwrite && pready;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_height <= 12'd480;
            r_cfg.texture_width <= 11'd64;
            r_cfg.tex_h_log2    <= 4'd6;
            r_cfg.ceiling_color <= 24'd0;
            r_cfg.floor_color   <= 24'd0;
        end else if (w_wr) begin
            unique case (w_index)
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[11:0];
                REG_TEXTURE_WIDTH: r_cfg.texture_width <= pwdata[10:0];
                REG_TEX_H_LOG2:    r_cfg.tex_h_log2    <= pwdata[3:0];
                REG_CEILING_COLOR: r_cfg.ceiling_color <= pwdata[23:0];
                REG_FLOOR_COLOR:   r_cfg.floor_color   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Configuration register reads
    always_comb begin
        unique case (w_index)
            REG_SCREEN_HEIGHT: prdata = 32'(r_cfg.screen_height);
            REG_TEXTURE_WIDTH: prdata = 32'(r_cfg.texture_width);
            REG_TEX_H_LOG2:    prdata = 32'(r_cfg.tex_h_log2);
            REG_CEILING_COLOR: prdata = 32'(r_cfg.ceiling_color);
            REG_FLOOR_COLOR:   prdata = 32'(r_cfg.floor_color);
            default:           prdata = '0;
        endcase
    end

    twc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    twc_datapath #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_TEX_SIZE    (MAX_TEX_SIZE),
        .MAX_SCREEN_ROWS (MAX_SCREEN_ROWS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_column         (i_column),
        .i_side           (i_side),
        .i_ray_dir_x      (i_ray_dir_x),
        .i_ray_dir_y      (i_ray_dir_y),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_wall_dist      (i_wall_dist),
        .i_line_height    (i_line_height),
        .i_draw_start     (i_draw_start),
        .i_draw_end       (i_draw_end),
        .o_out_column     (o_out_column),
        .o_row            (o_row),
        .o_region         (o_region),
        .o_texture_select (o_texture_select),
        .o_tex_x          (o_tex_x),
        .o_tex_y          (o_tex_y),
        .o_color          (o_color),
        .o_last           (o_last)
    );

endmodule

/* rtl/twc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; no package or submodule dependencies.
module twc_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   w_rem_sh;
    logic             w_qbit;
    logic [DEN_W-1:0] n_rem;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_rem_sh = {r_rem, r_num[NUM_W-1]};
        w_qbit   = (w_rem_sh >= {1'b0, r_den});
        n_rem    = w_qbit ? DEN_W'(w_rem_sh - {1'b0, r_den}) : w_rem_sh[DEN_W-1:0];
    end

    // Iterate one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], w_qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && (r_cnt == CNT_W'(NUM_W)))
        else $error("divider did not start");

endmodule

/* rtl/twc_datapath.sv */
// Datapath of the wall column renderer: column setup arithmetic, texture
// walk and pixel result registers. Depends on twc_pkg and twc_div.
module twc_datapath #(
    parameter int FRAC_BITS       = 16,
    parameter int MAX_TEX_SIZE    = 1024,
    parameter int MAX_SCREEN_ROWS = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  twc_pkg::t_cfg        i_cfg,
    input  twc_pkg::t_cmd        i_cmd,
    output twc_pkg::t_status     o_status,
    input  logic [11:0]          i_column,
    input  logic                 i_side,
    input  logic signed [31:0]   i_ray_dir_x,
    input  logic signed [31:0]   i_ray_dir_y,
    input  logic [31:0]          i_pos_x,
    input  logic [31:0]          i_pos_y,
    input  logic [31:0]          i_wall_dist,
    input  logic [15:0]          i_line_height,
    input  logic [10:0]          i_draw_start,
    input  logic [11:0]          i_draw_end,
    output logic [11:0]          o_out_column,
    output logic [10:0]          o_row,
    output logic [1:0]           o_region,
    output logic [1:0]           o_texture_select,
    output logic [9:0]           o_tex_x,
    output logic [9:0]           o_tex_y,
    output logic [23:0]          o_color,
    output logic                 o_last
);
    import twc_pkg::*;

    localparam int TEX_LOG_MAX = $clog2(MAX_TEX_SIZE + 1) - 1;
    localparam int NUM_W       = FRAC_BITS + TEX_LOG_MAX + 1;
    localparam int WIDE_W      = (NUM_W > 32) ? NUM_W : 33;
    localparam int ROW_W       = $clog2(MAX_SCREEN_ROWS);
    localparam int H_W         = $clog2(MAX_SCREEN_ROWS + 1);
    localparam int CMP_W       = ((H_W > 12) ? H_W : 12) + 1;
    localparam int D_W         = 18;
    localparam int TXP_W       = FRAC_BITS + 11;

    // Column state
    logic [11:0]          r_column;
    logic [10:0]          r_span_start;
    logic [11:0]          r_span_end;
    logic [1:0]           r_texture;
    logic                 r_mirror;
    logic [31:0]          r_dir;
    logic [31:0]          r_dist;
    logic [FRAC_BITS-1:0] r_pos_frac;
    logic [FRAC_BITS-1:0] r_mid;
    logic [FRAC_BITS-1:0] r_frac;
    logic [10:0]          r_tx_raw;
    logic [9:0]           r_tex_x;
    logic                 r_lh_zero;
    logic [D_W-1:0]       r_d;
    logic [31:0]          r_step;
    logic [31:0]          r_texpos;
    logic [ROW_W-1:0]     r_row;
    logic                 r_active;

    logic [H_W-1:0]       w_h;
    logic [12:0]          w_sh_ext;
    logic [3:0]           w_th_log;
    logic [NUM_W-1:0]     w_num;
    logic                 w_div_busy;
    logic [NUM_W-1:0]     w_quo;
    logic [WIDE_W-1:0]    w_quo_wide;
    logic [31:0]          w_step;
    logic [31:0]          w_d32;
    logic [31:0]          w_pos;
    logic signed [64:0]   w_prod;
    logic [TXP_W-1:0]     w_txp;
    logic [10:0]          w_mirror;
    logic                 w_dx_neg;
    logic                 w_dy_pos;
    logic signed [31:0]   w_shift;
    logic [31:0]          w_mask;
    logic [CMP_W-1:0]     w_row_c;
    logic                 w_last;

    // Effective screen height and texture height exponent
    always_comb begin
        w_sh_ext = {1'b0, i_cfg.screen_height};
        if (w_sh_ext == 13'd0) begin
            w_h = H_W'(1);
        end else if (w_sh_ext > 13'(MAX_SCREEN_ROWS)) begin
            w_h = H_W'(MAX_SCREEN_ROWS);
        end else begin
            w_h = H_W'(w_sh_ext);
        end
        w_th_log = (i_cfg.tex_h_log2 > 4'(TEX_LOG_MAX)) ? 4'(TEX_LOG_MAX) : i_cfg.tex_h_log2;
        w_num    = NUM_W'(1) << (6'(w_th_log) + 6'(FRAC_BITS));
    end

    // Texture step: texture height in Q format over line height
    twc_div #(
        .NUM_W (NUM_W),
        .DEN_W (16)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load_col),
        .i_num   (w_num),
        .i_den   (i_line_height),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Saturate the step to 32 bits; zero line height saturates too
    always_comb begin
        w_quo_wide = WIDE_W'(w_quo);
        if (r_lh_zero || (|w_quo_wide[WIDE_W-1:32])) begin
            w_step = 32'hFFFF_FFFF;
        end else begin
            w_step = w_quo_wide[31:0];
        end
        w_d32 = {{(32 - D_W){r_d[D_W-1]}}, r_d};
        w_pos = w_d32 * w_step;
    end

    // Hit point arithmetic; signed product so the shift floors negative offsets
    always_comb begin
        w_dx_neg = i_ray_dir_x[31];
        w_dy_pos = !i_ray_dir_y[31] && (i_ray_dir_y != 32'sd0);
        w_prod   = $signed({r_dir[31], r_dir}) * $signed({1'b0, r_dist});
        w_txp    = TXP_W'(r_frac) * TXP_W'(i_cfg.texture_width);
        w_mirror = i_cfg.texture_width - 11'd1 - r_tx_raw;
    end

    // Pixel region, texel row and bottom row flag
    always_comb begin
        w_shift = $signed(r_texpos) >>> FRAC_BITS;
        w_mask  = 32'((33'd1 << w_th_log) - 33'd1);
        w_row_c = CMP_W'(r_row);
        w_last  = (w_row_c + CMP_W'(1)) >= CMP_W'(w_h);
    end

    // Control state: column loaded and row counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_row    <= '0;
        end else if (i_cmd.load_col) begin
            r_active <= 1'b0;
            r_row    <= '0;
        end else if (i_cmd.pos_mul) begin
            r_active <= 1'b1;
            r_row    <= '0;
        end else if (i_cmd.pixel) begin
            if (w_last) begin
                r_active <= 1'b0;
                r_row    <= '0;
            end else begin
                r_row <= r_row + ROW_W'(1);
            end
        end
    end

    // Column setup sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_col) begin
            r_column     <= i_column;
            r_span_start <= i_draw_start;
            r_span_end   <= i_draw_end;
            r_dist       <= i_wall_dist;
            r_lh_zero    <= (i_line_height == 16'd0);
            r_d          <= D_W'(i_draw_start) + D_W'(i_line_height >> 1) - D_W'(w_h >> 1);
            if (i_side == 1'b0) begin
                r_texture  <= w_dx_neg ? TEX_WEST : TEX_EAST;
                r_mirror   <= w_dx_neg;
                r_dir      <= i_ray_dir_y;
                r_pos_frac <= i_pos_y[FRAC_BITS-1:0];
            end else begin
                r_texture  <= w_dy_pos ? TEX_SOUTH : TEX_NORTH;
                r_mirror   <= w_dy_pos;
                r_dir      <= i_ray_dir_x;
                r_pos_frac <= i_pos_x[FRAC_BITS-1:0];
            end
        end
        if (i_cmd.hit_mul) begin
            r_mid <= w_prod[2*FRAC_BITS-1:FRAC_BITS];
        end
        if (i_cmd.frac_add) begin
            r_frac <= r_mid + r_pos_frac;
        end
        if (i_cmd.tex_mul) begin
            r_tx_raw <= w_txp[TXP_W-1:FRAC_BITS];
        end
        if (i_cmd.tex_mirror) begin
            r_tex_x <= r_mirror ? w_mirror[9:0] : r_tx_raw[9:0];
        end
        if (i_cmd.pos_mul) begin
            r_step   <= w_step;
            r_texpos <= w_pos;
        end else if (i_cmd.pixel && (w_row_c >= CMP_W'(r_span_start))
                     && (w_row_c < CMP_W'(r_span_end))) begin
            r_texpos <= r_texpos + r_step;
        end
    end

    // Pixel result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.pixel) begin
            o_out_column     <= r_column;
            o_row            <= 11'(r_row);
            o_texture_select <= r_texture;
            o_last           <= w_last;
            if (w_row_c < CMP_W'(r_span_start)) begin
                o_region <= RGN_CEILING;
                o_tex_x  <= '0;
                o_tex_y  <= '0;
                o_color  <= i_cfg.ceiling_color;
            end else if (w_row_c < CMP_W'(r_span_end)) begin
                o_region <= RGN_WALL;
                o_tex_x  <= r_tex_x;
                o_tex_y  <= 10'(w_shift & w_mask);
                o_color  <= '0;
            end else begin
                o_region <= RGN_FLOOR;
                o_tex_x  <= '0;
                o_tex_y  <= '0;
                o_color  <= i_cfg.floor_color;
            end
        end
    end

    assign o_status.div_busy   = w_div_busy;
    assign o_status.col_active = r_active;

    a_last_unloads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pixel && w_last) |=> !r_active && (r_row == '0))
        else $error("column still loaded after bottom row");

    a_setup_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pos_mul |=> r_active && (r_row == '0) && (r_step == $past(w_step)))
        else $error("column setup did not load the walk");

endmodule

/* rtl/twc_ctrl.sv */
// Controller of the wall column renderer: request handshake, column setup
// sequence and result valid flag. Depends on twc_pkg.
module twc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_func,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  twc_pkg::t_status  i_status,
    output twc_pkg::t_cmd     o_cmd
);
    import twc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT,
        S_FRAC,
        S_TEX,
        S_MIRROR,
        S_WAIT,
        S_POS
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;

    // Decode commands and next state
    always_comb begin
        o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
        w_accept   = i_in_valid && o_in_ready;

        o_cmd            = '0;
        o_cmd.load_col   = w_accept && (i_func == FUNC_START);
        o_cmd.pixel      = w_accept && (i_func == FUNC_PIXEL) && i_status.col_active;
        o_cmd.hit_mul    = (r_state == S_HIT);
        o_cmd.frac_add   = (r_state == S_FRAC);
        o_cmd.tex_mul    = (r_state == S_TEX);
        o_cmd.tex_mirror = (r_state == S_MIRROR);
        o_cmd.pos_mul    = (r_state == S_POS);

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.load_col) begin
                    n_state = S_HIT;
                end
            end
            S_HIT:    n_state = S_FRAC;
            S_FRAC:   n_state = S_TEX;
            S_TEX:    n_state = S_MIRROR;
            S_MIRROR: n_state = S_WAIT;
            S_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_POS;
                end
            end
            S_POS:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase

        // Hold a result until taken; set on each emitted pixel
        if (o_cmd.pixel) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_pos_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS) |-> !i_status.div_busy)
        else $error("step used before divider finished");

    a_load_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_col |=> (r_state == S_HIT) && !o_in_ready)
        else $error("column setup did not block requests");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.pixel)
        else $error("pending result overwritten");

endmodule

/* sim/tb_textured_wall_column_renderer_unit.sv */
// Self-checking testbench for the textured wall column renderer: directed columns, then
// random column streams under random gaps and stalls, checked against a built-in predictor.
// Depends on twc_pkg and textured_wall_column_renderer_unit.
module tb_textured_wall_column_renderer_unit;
    import twc_pkg::*;

    localparam int FRAC          = 16;
    localparam int MAX_ROWS      = 2048;
    localparam int MAX_TEX       = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_ITEMS  = 600;
    localparam int STREAM_ITEMS  = 100;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic        func;
        logic [11:0] column;
        logic        side;
        logic [31:0] ray_dx;
        logic [31:0] ray_dy;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] hit_dist;
        logic [15:0] line_h;
        logic [10:0] draw_start;
        logic [11:0] draw_end;
    } t_ray_req;

    typedef struct packed {
        logic [11:0] column;
        logic [10:0] row;
        logic [1:0]  region;
        logic [1:0]  tex_sel;
        logic [9:0]  tex_x;
        logic [9:0]  tex_y;
        logic [23:0] color;
        logic        last;
    } t_pixel;

    logic        clk;
    logic        rst_n;
    logic        apb_sel;
    logic        apb_enable;
    logic        apb_write;
    logic [4:0]  apb_addr;
    logic [31:0] apb_wdata;
    logic [31:0] apb_rdata;
    logic        apb_ready;
    logic        in_valid;
    logic        in_ready;
    t_ray_req    req_bus;
    logic        out_valid;
    logic        out_ready;
    t_pixel      pix_bus;

    // Shadow configuration and column state of the predictor
    t_cfg        shadow_cfg;
    logic [11:0] col_index;
    int unsigned row_next;
    logic [31:0] tex_pos;
    logic [31:0] tex_step;
    logic [9:0]  col_tex_x;
    logic [1:0]  col_texture;
    logic [10:0] span_top;
    logic [11:0] span_bottom;
    bit          col_loaded;

    t_pixel      pending_pixels[$];
    int unsigned served_requests;
    int unsigned fail_count;
    int unsigned cycle_count;
    bit          traffic_gaps;
    bit          long_hold_due;

    textured_wall_column_renderer_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .psel             (apb_sel),
        .penable          (apb_enable),
        .pwrite           (apb_write),
        .paddr            (apb_addr),
        .pwdata           (apb_wdata),
        .prdata           (apb_rdata),
        .pready           (apb_ready),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_func           (req_bus.func),
        .i_column         (req_bus.column),
        .i_side           (req_bus.side),
        .i_ray_dir_x      (req_bus.ray_dx),
        .i_ray_dir_y      (req_bus.ray_dy),
        .i_pos_x          (req_bus.pos_x),
        .i_pos_y          (req_bus.pos_y),
        .i_wall_dist      (req_bus.hit_dist),
        .i_line_height    (req_bus.line_h),
        .i_draw_start     (req_bus.draw_start),
        .i_draw_end       (req_bus.draw_end),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_column     (pix_bus.column),
        .o_row            (pix_bus.row),
        .o_region         (pix_bus.region),
        .o_texture_select (pix_bus.tex_sel),
        .o_tex_x          (pix_bus.tex_x),
        .o_tex_y          (pix_bus.tex_y),
        .o_color          (pix_bus.color),
        .o_last           (pix_bus.last)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // Clamp the row count to one..MAX_ROWS
    function automatic int unsigned visible_rows();
        int unsigned h;
        h = shadow_cfg.screen_height;
        if (h == 0) h = 1;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return h;
    endfunction

    // Cap the texture height at MAX_TEX
    function automatic int unsigned texel_rows();
        return (shadow_cfg.tex_h_log2 > 10) ? MAX_TEX : (1 << shadow_cfg.tex_h_log2);
    endfunction

    function automatic void load_column(input t_ray_req r);
        logic [31:0] dir;
        logic [31:0] pos;
        logic        mirror;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] frac;
        logic [63:0] tx;
        logic [63:0] quot;
        logic [63:0] span_off;
        col_index   = r.column;
        span_top    = r.draw_start;
        span_bottom = r.draw_end;
        if (r.side == 1'b0) begin
            mirror      = r.ray_dx[31];
            col_texture = mirror ? TEX_WEST : TEX_EAST;
            dir         = r.ray_dy;
            pos         = r.pos_y;
        end else begin
            mirror      = !r.ray_dy[31] && (r.ray_dy != 32'd0);
            col_texture = mirror ? TEX_SOUTH : TEX_NORTH;
            dir         = r.ray_dx;
            pos         = r.pos_x;
        end
        // Floor the hit offset: multiply magnitudes, then negate for a negative direction
        mag  = dir[31] ? (64'h1_0000_0000 - {32'd0, dir}) : {32'd0, dir};
        prod = mag * {32'd0, r.hit_dist};
        if (dir[31]) prod = -prod;
        frac = ((prod >> FRAC) + {32'd0, pos}) & ((64'd1 << FRAC) - 64'd1);
        tx   = (frac * 64'(shadow_cfg.texture_width)) >> FRAC;
        if (mirror) tx = 64'(shadow_cfg.texture_width) - 64'd1 - tx;
        col_tex_x = tx[9:0];
        // Saturate the step on a zero line height or a quotient beyond 32 bits
        if (r.line_h == 16'd0) begin
            tex_step = '1;
        end else begin
            quot     = (64'(texel_rows()) << FRAC) / 64'(r.line_h);
            tex_step = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
        end
        span_off   = 64'(r.draw_start) - 64'(visible_rows() / 2) + 64'(r.line_h / 2);
        prod       = span_off * 64'(tex_step);
        tex_pos    = prod[31:0];
        row_next   = 0;
        col_loaded = 1'b1;
    endfunction

    // Apply one accepted request; return 0 when the block ignores it
    function automatic bit advance_renderer(input t_ray_req r);
        t_pixel      px;
        int unsigned row;
        logic [31:0] ypos;
        if (r.func == FUNC_START) begin
            load_column(r);
            return 1'b1;
        end
        if (!col_loaded) return 1'b0;
        row        = row_next;
        px         = '0;
        px.column  = col_index;
        px.row     = row[10:0];
        px.tex_sel = col_texture;
        if (row < span_top) begin
            px.region = RGN_CEILING;
            px.color  = shadow_cfg.ceiling_color;
        end else if (row < span_bottom) begin
            px.region = RGN_WALL;
            px.tex_x  = col_tex_x;
            ypos      = $signed(tex_pos) >>> FRAC;
            px.tex_y  = ypos[9:0] & 10'(texel_rows() - 1);
            tex_pos   = tex_pos + tex_step;
        end else begin
            px.region = RGN_FLOOR;
            px.color  = shadow_cfg.floor_color;
        end
        px.last = (row + 1 >= visible_rows());
        if (px.last) begin
            col_loaded = 1'b0;
            row_next   = 0;
        end else begin
            row_next = row + 1;
        end
        pending_pixels.push_back(px);
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- request builders

    function automatic t_ray_req random_fields();
        t_ray_req r;
        r.func       = 1'($urandom());
        r.column     = 12'($urandom());
        r.side       = 1'($urandom());
        r.ray_dx     = $urandom();
        r.ray_dy     = $urandom();
        r.pos_x      = $urandom();
        r.pos_y      = $urandom();
        r.hit_dist   = $urandom();
        r.line_h     = 16'($urandom());
        r.draw_start = 11'($urandom());
        r.draw_end   = 12'($urandom());
        return r;
    endfunction

    function automatic t_ray_req pixel_req();
        t_ray_req r;
        r      = random_fields();
        r.func = FUNC_PIXEL;
        return r;
    endfunction

    function automatic t_ray_req column_req(input logic [11:0] column, input logic side,
                                            input logic [31:0] dx, input logic [31:0] dy,
                                            input logic [31:0] px, input logic [31:0] py,
                                            input logic [31:0] wall_dist, input logic [15:0] lh,
                                            input logic [10:0] ds, input logic [11:0] de);
        return '{func: FUNC_START, column: column, side: side, ray_dx: dx, ray_dy: dy,
                 pos_x: px, pos_y: py, hit_dist: wall_dist, line_h: lh, draw_start: ds,
                 draw_end: de};
    endfunction

    // Random column start, spans mostly inside the screen
    function automatic t_ray_req random_column_req(input int unsigned rows);
        t_ray_req r;
        r      = random_fields();
        r.func = FUNC_START;
        case ($urandom_range(0, 4))
            0: r.ray_dx = 32'd0;
            1: r.ray_dx = $urandom_range(0, 32'h3FFFF) - 32'h20000;
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0: r.ray_dy = 32'd0;
            1: r.ray_dy = $urandom_range(0, 32'h3FFFF) - 32'h20000;
            default: ;
        endcase
        if ($urandom_range(0, 1) == 0) r.hit_dist = $urandom_range(0, 32'h000F_FFFF);
        if ($urandom_range(0, 9) < 7) r.draw_start = 11'($urandom_range(0, rows));
        if ($urandom_range(0, 9) < 7) r.draw_end = 12'($urandom_range(0, rows + 1));
        case ($urandom_range(0, 9))
            0: r.line_h = 16'd0;
            1, 2: ;
            3, 4, 5: r.line_h = 16'($urandom_range(1, 3 * rows));
            default: r.line_h = (r.draw_end > r.draw_start) ?
                                16'(r.draw_end - r.draw_start) : 16'd1;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Send one request; enter and leave at a falling edge
    task automatic send_request(input t_ray_req r);
        if (traffic_gaps && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_bus  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (advance_renderer(r)) served_requests++;
        @(negedge clk);
    endtask

    task automatic send_pixels(input int unsigned n);
        repeat (n) send_request(pixel_req());
    endtask

    // A setup phase, then an access phase held until ready; the caller closes the transfer
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= 1'b1;
        apb_addr   <= {idx, 2'b00};
        apb_wdata  <= value;
        @(negedge clk);
        apb_enable <= 1'b1;
        @(posedge clk);
        while (!apb_ready) @(posedge clk);
        case (idx)
            REG_SCREEN_HEIGHT: shadow_cfg.screen_height = value[11:0];
            REG_TEXTURE_WIDTH: shadow_cfg.texture_width = value[10:0];
            REG_TEX_H_LOG2:    shadow_cfg.tex_h_log2    = value[3:0];
            REG_CEILING_COLOR: shadow_cfg.ceiling_color = value[23:0];
            REG_FLOOR_COLOR:   shadow_cfg.floor_color   = value[23:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [11:0] rows, input logic [10:0] width,
                              input logic [3:0] h_log2, input logic [23:0] ceiling,
                              input logic [23:0] ground);
        write_reg(REG_SCREEN_HEIGHT, 32'(rows));
        write_reg(REG_TEXTURE_WIDTH, 32'(width));
        write_reg(REG_TEX_H_LOG2, 32'(h_log2));
        write_reg(REG_CEILING_COLOR, 32'(ceiling));
        write_reg(REG_FLOOR_COLOR, 32'(ground));
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
    endtask

    // Drop valid, drain all pixels, then let a column start finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_unloaded_pixel();
        send_request(pixel_req());
    endtask

    // Zero line height, west wall, negative extremes, wall running past the screen
    task automatic test_zero_line_height();
        wait_idle();
        set_config(12'd6, 11'd1024, 4'd10, 24'hFFFFFF, 24'h000000);
        send_request(column_req(12'hFFF, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h0,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 11'd1, 12'd2048));
        send_pixels(6);
    endtask

    // Zero screen height, empty span, south and north walls, negative hit point
    task automatic test_degenerate_span();
        wait_idle();
        set_config(12'd0, 11'd1, 4'd15, 24'h000000, 24'hFFFFFF);
        send_request(column_req(12'd0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                32'h0, 32'h0, 16'hFFFF, 11'd2047, 12'd0));
        send_pixels(1);
        send_request(column_req(12'd17, 1'b1, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000,
                                32'h0, 32'h0003_0000, 16'd1, 11'd0, 12'd1));
        // the column is unloaded after its last row
        send_pixels(2);
    endtask

    // East wall dropped halfway by a west wall
    task automatic test_column_restart();
        wait_idle();
        set_config(12'd5, 11'd64, 4'd0, 24'h123456, 24'h654321);
        send_request(column_req(12'd100, 1'b0, 32'h0001_0000, 32'h0000_8000, 32'h0,
                                32'h0002_8000, 32'h0002_0000, 16'd3, 11'd1, 12'd4));
        send_pixels(2);
        send_request(column_req(12'd101, 1'b0, 32'hFFFF_0000, 32'hFFFF_4000, 32'h0,
                                32'h0001_C000, 32'h0001_8000, 16'd8, 11'd0, 12'd3));
        send_pixels(5);
    endtask

    // Saturated maximum height: walk the top rows through the wall; the next start drops it
    task automatic test_full_screen_column();
        wait_idle();
        set_config(12'hFFF, 11'h7FF, 4'd6, 24'($urandom()), 24'($urandom()));
        send_request(column_req(12'($urandom()), 1'b1, $urandom(), $urandom(), $urandom(),
                                $urandom(), 32'h0004_0000, 16'd200, 11'd40, 12'd100));
        send_pixels(120);
    endtask

    // Hold the output off for a long stretch while pixels keep coming
    task automatic test_output_stall();
        wait_idle();
        set_config(12'd40, 11'd64, 4'd6, 24'($urandom()), 24'($urandom()));
        long_hold_due = 1'b1;
        send_request(random_column_req(40));
        send_pixels(40);
    endtask

    // One configuration, then columns of random content until the budget is spent
    task automatic run_phase(input int unsigned budget, input bit gaps);
        logic [11:0] rows_cfg;
        logic [10:0] width_cfg;
        int unsigned rows;
        int unsigned n;
        int unsigned goal;
        wait_idle();
        case ($urandom_range(0, 9))
            0: rows_cfg = 12'd0;
            1: rows_cfg = 12'($urandom_range(25, 64));
            default: rows_cfg = 12'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 5))
            0: width_cfg = 11'd1;
            1: width_cfg = 11'd1024;
            2: width_cfg = 11'h7FF;
            3: width_cfg = 11'($urandom());
            default: width_cfg = 11'($urandom_range(1, 1024));
        endcase
        set_config(rows_cfg, width_cfg, 4'($urandom_range(0, 15)), 24'($urandom()),
                   24'($urandom()));
        traffic_gaps = gaps;
        rows = visible_rows();
        goal = served_requests + budget;
        while (served_requests < goal) begin
            if ($urandom_range(0, 9) == 0) send_request(pixel_req());
            send_request(random_column_req(rows));
            case ($urandom_range(0, 9))
                0: n = $urandom_range(0, rows - 1);
                1: n = rows + $urandom_range(1, 3);
                default: n = rows;
            endcase
            send_pixels(n);
        end
    endtask

    task automatic test_random_columns();
        int unsigned goal;
        goal = served_requests + RANDOM_ITEMS;
        while (served_requests < goal)
            run_phase($urandom_range(60, 160), $urandom_range(0, 3) != 0);
    endtask

    task automatic test_streaming();
        run_phase(STREAM_ITEMS, 1'b0);
    endtask

    // ---------------------------------------------------------------- result side

    // Stall the output in random bursts, or for one long stretch on request
    initial begin : output_stall
        int unsigned stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (traffic_gaps && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each pixel with the oldest prediction
    always @(posedge clk) begin : check_pixels
        t_pixel want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected pixel: col %0d row %0d region %0d", pix_bus.column,
                             pix_bus.row, pix_bus.region);
            end else begin
                want = pending_pixels.pop_front();
                if (want.column != pix_bus.column || want.row != pix_bus.row ||
                    want.region != pix_bus.region || want.tex_sel != pix_bus.tex_sel ||
                    want.tex_x != pix_bus.tex_x || want.tex_y != pix_bus.tex_y ||
                    want.color != pix_bus.color || want.last != pix_bus.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("pixel mismatch, expected col %0d row %0d rgn %0d tex %0d",
                                 want.column, want.row, want.region, want.tex_sel);
                        $display("  x %0d y %0d color %06h last %0d", want.tex_x, want.tex_y,
                                 want.color, want.last);
                        $display("  got col %0d row %0d rgn %0d tex %0d", pix_bus.column,
                                 pix_bus.row, pix_bus.region, pix_bus.tex_sel);
                        $display("  x %0d y %0d color %06h last %0d", pix_bus.tex_x,
                                 pix_bus.tex_y, pix_bus.color, pix_bus.last);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        rst_n           = 1'b0;
        apb_sel         = 1'b0;
        apb_enable      = 1'b0;
        apb_write       = 1'b0;
        apb_addr        = '0;
        apb_wdata       = '0;
        in_valid        = 1'b0;
        req_bus         = '0;
        traffic_gaps    = 1'b1;
        long_hold_due   = 1'b0;
        served_requests = 0;
        fail_count      = 0;
        cycle_count     = 0;
        col_loaded      = 1'b0;
        col_index       = '0;
        row_next        = 0;
        tex_pos         = '0;
        tex_step        = '0;
        col_tex_x       = '0;
        col_texture     = TEX_EAST;
        span_top        = '0;
        span_bottom     = '0;
        shadow_cfg      = '{screen_height: 12'd480, texture_width: 11'd64, tex_h_log2: 4'd6,
                            ceiling_color: 24'd0, floor_color: 24'd0};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_unloaded_pixel();
        test_zero_line_height();
        test_degenerate_span();
        test_column_restart();
        test_full_screen_column();
        test_output_stall();
        test_random_columns();
        test_streaming();
        wait_idle();

        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
